@@ rtl/prpm_pkg.sv @@
// Shared types, constants and register codes of the pulse-rate power meter.
`timescale 1ns / 1ps

package prpm_pkg;

	// Default widths for the top-level parameters
	localparam int TIME_BITS_DEF   = 32;
	localparam int SAMPLE_BITS_DEF = 10;

	// Fixed field widths
	localparam int THRESH_BITS = 10;
	localparam int MS_BITS     = 16;
	localparam int COUNT_BITS  = 8;
	localparam int POWER_BITS  = 26;
	localparam int CMP_BITS    = 16;
	localparam int WIDE_BITS   = 64;
	localparam int PROD_BITS   = POWER_BITS + COUNT_BITS;
	localparam int CFG_BITS    = POWER_BITS;
	localparam int INDEX_BITS  = 3;

	// Divider sequencing
	localparam int DIV_STEPS    = POWER_BITS;
	localparam int STEP_BITS    = $clog2(DIV_STEPS);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [POWER_BITS-1:0] POWER_MAX = {POWER_BITS{1'b1}};

	// Register indexes on the configuration port
	typedef enum logic [INDEX_BITS-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_COOLDOWN  = 3'd1,
		CFG_PER_REPORT = 3'd2,
		CFG_HOLD      = 3'd3,
		CFG_SCALE     = 3'd4
	} cfg_index_t;

	// Reset values of the registers
	localparam logic [THRESH_BITS-1:0] THRESHOLD_RST  = 10'd10;
	localparam logic [MS_BITS-1:0]     COOLDOWN_RST   = 16'd20;
	localparam logic [COUNT_BITS-1:0]  PER_REPORT_RST = 8'd5;
	localparam logic [MS_BITS-1:0]     HOLD_RST       = 16'd100;
	localparam logic [POWER_BITS-1:0]  SCALE_RST      = 26'd3600000;
	localparam logic [COUNT_BITS-1:0]  MIN_TARGET     = 8'd2;

	typedef struct packed {
		logic [THRESH_BITS-1:0] threshold;
		logic [MS_BITS-1:0]     cooldown;
		logic [COUNT_BITS-1:0]  per_report;
		logic [MS_BITS-1:0]     hold;
		logic [POWER_BITS-1:0]  scale;
	} cfg_t;

	// One classified word handed from front to back
	typedef struct packed {
		logic                   seen;
		logic                   report;
		logic                   indicator;
		logic                   skip;
		logic [POWER_BITS-1:0]  divisor;
		logic [COUNT_BITS-1:0]  mult;
	} job_t;

endpackage

@@ rtl/prpm_front.sv @@
// Front part: pulse detection, indicator and window bookkeeping per sample.
`timescale 1ns / 1ps

module prpm_front import prpm_pkg::*; #(
	parameter int TIME_BITS   = TIME_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIME_BITS-1:0]   now_ms,
	input  logic [SAMPLE_BITS-1:0] light_sample,
	input  logic                   q_full,
	output logic                   q_push,
	output job_t                   q_job
);

	logic [COUNT_BITS-1:0] count_q;
	logic                  started_q;
	logic [TIME_BITS-1:0]  start_time_q;
	logic [TIME_BITS-1:0]  last_time_q;
	logic                  indicator_q;

	logic [TIME_BITS-1:0]  since;
	logic [TIME_BITS-1:0]  elapsed;
	logic [WIDE_BITS-1:0]  elapsed_wide;
	logic [COUNT_BITS-1:0] target;
	logic [COUNT_BITS-1:0] count_next;
	logic                  pulse;
	logic                  report;
	logic                  indicator_next;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Classify the sample against the current window state
	always_comb begin
		since        = now_ms - last_time_q;
		elapsed      = now_ms - start_time_q;
		elapsed_wide = WIDE_BITS'(elapsed);
		target       = (cfg.per_report < MIN_TARGET) ? MIN_TARGET : cfg.per_report;
		count_next   = count_q + COUNT_BITS'(1);
		pulse        = (since > TIME_BITS'(cfg.cooldown)) &&
		               (CMP_BITS'(light_sample) > CMP_BITS'(cfg.threshold));
		report       = pulse && (count_next >= target);
		if (pulse) begin
			indicator_next = 1'b1;
		end else if (since > TIME_BITS'(cfg.hold)) begin
			indicator_next = 1'b0;
		end else begin
			indicator_next = indicator_q;
		end
		q_job.seen      = pulse;
		q_job.report    = report;
		q_job.indicator = indicator_next;
		// a zero interval or one wider than the dividend gives zero power
		q_job.skip      = (elapsed == '0) || (|elapsed_wide[WIDE_BITS-1:POWER_BITS]);
		q_job.divisor   = elapsed_wide[POWER_BITS-1:0];
		q_job.mult      = target - COUNT_BITS'(1);
	end

	// Advance the window state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			started_q    <= 1'b0;
			start_time_q <= '0;
			last_time_q  <= '0;
			indicator_q  <= 1'b0;
		end else if (q_push) begin
			indicator_q <= indicator_next;
			if (pulse) begin
				last_time_q <= now_ms;
				if (report) begin
					count_q      <= '0;
					started_q    <= 1'b0;
					start_time_q <= '0;
				end else begin
					count_q <= count_next;
					if (!started_q) begin
						started_q    <= 1'b1;
						start_time_q <= now_ms;
					end
				end
			end
		end
	end

endmodule

@@ rtl/prpm_queue.sv @@
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module prpm_queue import prpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t pop_job
);

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + QPTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_BITS'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_BITS'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/prpm_back.sv @@
// Back part: iterative power division, multiply, saturation and output register.
`timescale 1ns / 1ps

module prpm_back import prpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [POWER_BITS-1:0] scale,
	input  logic                  q_valid,
	input  job_t                  q_job,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  pulse_seen,
	output logic                  power_valid,
	output logic [POWER_BITS-1:0] power_value,
	output logic                  indicator_on
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t                state_q;
	job_t                  job_q;
	logic [POWER_BITS-1:0] rem_q;
	logic [POWER_BITS-1:0] quo_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic                  out_valid_q;
	logic                  seen_q;
	logic                  pvalid_q;
	logic [POWER_BITS-1:0] power_q;
	logic                  ind_q;

	logic [POWER_BITS:0]   shifted;
	logic                  fits;
	logic                  out_free;

	assign q_pop        = (state_q == ST_IDLE) && q_valid;
	assign out_free     = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign pulse_seen   = seen_q;
	assign power_valid  = pvalid_q;
	assign power_value  = power_q;
	assign indicator_on = ind_q;

	// One restoring step: shift in the next dividend bit and try to subtract
	always_comb begin
		shifted = {rem_q, quo_q[POWER_BITS-1]};
		fits    = shifted >= {1'b0, job_q.divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			job_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			prod_q      <= '0;
			seen_q      <= 1'b0;
			pvalid_q    <= 1'b0;
			power_q     <= '0;
			ind_q       <= 1'b0;
		end else begin
			// drop the result once it is taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						job_q <= q_job;
						rem_q <= '0;
						quo_q <= scale;
						step_q <= STEP_BITS'(DIV_STEPS - 1);
						prod_q <= '0;
						if (q_job.report && !q_job.skip) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					rem_q <= fits ? POWER_BITS'(shifted - {1'b0, job_q.divisor})
					              : shifted[POWER_BITS-1:0];
					quo_q <= {quo_q[POWER_BITS-2:0], fits};
					step_q <= step_q - STEP_BITS'(1);
					if (step_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_BITS'(quo_q) * PROD_BITS'(job_q.mult);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						seen_q      <= job_q.seen;
						pvalid_q    <= job_q.report;
						ind_q       <= job_q.indicator;
						power_q     <= (|prod_q[PROD_BITS-1:POWER_BITS]) ? POWER_MAX
						               : prod_q[POWER_BITS-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/pulse_rate_power_meter_top.sv @@
// Top level of the pulse-rate power meter: registers, front, queue and back.
//
//   channel   direction   handshake            word
//   in        into block  in_valid / in_stall    now_ms, light_sample
//   out       from block  out_valid / out_stall  pulse_seen, power_valid, power_value,
//                                               indicator_on
//   cfg       into block  cfg_we (no wait)       cfg_index, cfg_data
//
// The front takes one sample word per cycle while the two-entry queue has room.
// A word that does not report power, or that gives zero power, goes from idle to emit;
// a reporting word first passes the 26-step shift-subtract divider and the multiply.
// Reset clears the window state, the queue and the output register at once.
// A stalled output holds its word; the back waits in emit, the front fills the queue.
`timescale 1ns / 1ps

module pulse_rate_power_meter_top import prpm_pkg::*; #(
	parameter int TIME_BITS   = TIME_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]    cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIME_BITS-1:0]   now_ms,
	input  logic [SAMPLE_BITS-1:0] light_sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   pulse_seen,
	output logic                   power_valid,
	output logic [POWER_BITS-1:0]  power_value,
	output logic                   indicator_on
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	job_t push_job;
	logic q_pop;
	logic q_valid;
	job_t pop_job;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.cooldown   <= COOLDOWN_RST;
			cfg_q.per_report <= PER_REPORT_RST;
			cfg_q.hold       <= HOLD_RST;
			cfg_q.scale      <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  cfg_q.threshold  <= cfg_data[THRESH_BITS-1:0];
				CFG_COOLDOWN:   cfg_q.cooldown   <= cfg_data[MS_BITS-1:0];
				CFG_PER_REPORT: cfg_q.per_report <= cfg_data[COUNT_BITS-1:0];
				CFG_HOLD:       cfg_q.hold       <= cfg_data[MS_BITS-1:0];
				CFG_SCALE:      cfg_q.scale      <= cfg_data[POWER_BITS-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	prpm_front #(
		.TIME_BITS   (TIME_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.light_sample (light_sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	prpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_job   (pop_job)
	);

	prpm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale        (cfg_q.scale),
		.q_valid      (q_valid),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pulse_seen   (pulse_seen),
		.power_valid  (power_valid),
		.power_value  (power_value),
		.indicator_on (indicator_on)
	);

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the pulse-rate power meter: directed and random sample words.
`timescale 1ns / 1ps

module tb_top;
	import prpm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 40;
	localparam int SCALE_TOP   = 67108863;

	typedef enum int {PACE_STEADY, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

	typedef struct packed {
		bit        seen;
		bit        valid;
		bit [25:0] power;
		bit        lamp;
	} meter_word_t;

	// Meter predictor plus the store of readings still due from the block
	class meter_scoreboard;
		bit [9:0]    threshold;
		bit [15:0]   cooldown;
		bit [7:0]    per_report;
		bit [15:0]   hold;
		bit [25:0]   scale;
		bit [7:0]    count;
		bit          started;
		bit [31:0]   start_ms;
		bit [31:0]   last_ms;
		bit          lamp;
		meter_word_t due_readings[$];
		int          errors;

		function new();
			threshold  = 10;
			cooldown   = 20;
			per_report = 5;
			hold       = 100;
			scale      = 3600000;
			count      = 0;
			started    = 0;
			start_ms   = 0;
			last_ms    = 0;
			lamp       = 0;
			errors     = 0;
		endfunction

		function void set_config(int th, int cd, int pr, int hd, int sc);
			threshold  = 10'(th);
			cooldown   = 16'(cd);
			per_report = 8'(pr);
			hold       = 16'(hd);
			scale      = 26'(sc);
		endfunction

		// Work out the reading one accepted sample word causes
		function void take_sample(bit [31:0] now, bit [9:0] sample);
			bit [31:0]   since;
			bit [31:0]   elapsed;
			bit [7:0]    target;
			bit [63:0]   prod;
			meter_word_t w;
			since  = now - last_ms;
			target = (per_report < 2) ? 8'd2 : per_report;
			w      = '0;
			if (since > hold)
				lamp = 0;
			if (since > cooldown && sample > threshold) begin
				w.seen  = 1;
				last_ms = now;
				lamp    = 1;
				count   = count + 8'd1;
				if (count >= target) begin
					elapsed = now - start_ms;
					w.valid = 1;
					if (elapsed != 0) begin
						prod = (64'(scale) / 64'(elapsed)) * (64'(target) - 64'd1);
						w.power = (prod > 64'(POWER_MAX)) ? POWER_MAX : prod[25:0];
					end
					count    = 0;
					started  = 0;
					start_ms = 0;
				end else if (!started) begin
					started  = 1;
					start_ms = now;
				end
			end
			w.lamp = lamp;
			due_readings.push_back(w);
		endfunction

		function void match(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, want, got);
			end
		endfunction

		// Compare one reading from the block with the oldest one due
		function void check_reading(meter_word_t got);
			meter_word_t want;
			if (due_readings.size() == 0) begin
				errors++;
				$display({"%0t: reading with none expected, ",
					"actual seen=%0d valid=%0d power=%0d lamp=%0d"},
					$time, got.seen, got.valid, got.power, got.lamp);
			end else begin
				want = due_readings.pop_front();
				match("pulse_seen", want.seen, got.seen);
				match("power_valid", want.valid, got.valid);
				match("power_value", want.power, got.power);
				match("indicator_on", want.lamp, got.lamp);
			end
		endfunction

		function int pending();
			return due_readings.size();
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_BITS-1:0]   cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [31:0]           now_ms       = '0;
	logic [9:0]            light_sample = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic                  pulse_seen;
	logic                  power_valid;
	logic [POWER_BITS-1:0] power_value;
	logic                  indicator_on;

	meter_scoreboard sb = new();
	meter_word_t     got_word;
	int              cycle_count = 0;
	int              send_idle_pct = 0;
	int              stall_pct = 0;
	int              hold_asks = 0;
	int              hold_served = 0;
	int              cur_th = 10;
	int              cur_cd = 20;
	int              cur_hold = 100;
	bit [31:0]       clock_ms = '0;

	pulse_rate_power_meter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.light_sample (light_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pulse_seen   (pulse_seen),
		.power_valid  (power_valid),
		.power_value  (power_value),
		.indicator_on (indicator_on)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Watch both channels at the edge where a word moves
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.take_sample(now_ms, light_sample);
		if (arst_n && out_valid && !out_stall) begin
			got_word = '{pulse_seen, power_valid, power_value, indicator_on};
			sb.check_reading(got_word);
		end
	end

	// Receiver: random stall, or a long hold-off when one is asked for
	initial begin
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				hold_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one sample word, after a random gap, and hold it until taken
	task automatic send_word(input bit [31:0] t, input bit [9:0] s);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		now_ms       <= t;
		light_sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid and wait until every reading has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_BITS'(val);
		@(posedge clk);
	endtask

	// Write all five registers once the block is idle
	task automatic configure(input int th, input int cd, input int pr, input int hd,
		input int sc);
		settle();
		write_reg(CFG_THRESHOLD, th);
		write_reg(CFG_COOLDOWN, cd);
		write_reg(CFG_PER_REPORT, pr);
		write_reg(CFG_HOLD, hd);
		write_reg(CFG_SCALE, sc);
		cfg_we <= 1'b0;
		sb.set_config(th, cd, pr, hd, sc);
		cur_th   = th;
		cur_cd   = cd;
		cur_hold = hd;
	endtask

	// Advance time around the cooldown and hold edges and offer a sample
	task automatic random_item();
		int        r;
		bit [31:0] step_ms;
		bit [9:0]  s;
		r = $urandom_range(99);
		if (r < 35)
			step_ms = cur_cd + $urandom_range(3, 1);
		else if (r < 55)
			step_ms = $urandom_range(cur_cd);
		else if (r < 75) begin
			step_ms = cur_hold + $urandom_range(2);
			if (step_ms != 0)
				step_ms = step_ms - 1;
		end else if (r < 92)
			step_ms = $urandom_range(2 * (cur_cd + cur_hold) + 40);
		else if (r < 96)
			step_ms = 0;
		else
			step_ms = $urandom();
		clock_ms = clock_ms + step_ms;
		r = $urandom_range(99);
		if (r < 10)
			s = 10'(cur_th);
		else if (r < 60 && cur_th != 1023)
			s = 10'($urandom_range(1023, cur_th + 1));
		else
			s = 10'($urandom_range(1023));
		send_word(clock_ms, s);
	endtask

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_STEADY: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			PACE_SENDER: begin
				send_idle_pct = 56;
				stall_pct     = 0;
			end
			PACE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct     = 56;
			end
			default: begin
				send_idle_pct = 29;
				stall_pct     = 29;
			end
		endcase
	endtask

	// One random phase; a squeezed phase adds a long receiver hold-off and a full drain
	task automatic run_phase(input pace_t pace, input bit squeeze, input int th, input int cd,
		input int pr, input int hd, input int sc, input int n);
		configure(th, cd, pr, hd, sc);
		set_pace(pace);
		clock_ms = $urandom();
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == n / 3)
				hold_asks++;
			if (squeeze && i == (2 * n) / 3)
				settle();
			random_item();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: cooldown and threshold edges, a full window, indicator timeout
		send_word(32'd0, 10'd0);
		send_word(32'd21, 10'd11);
		send_word(32'd30, 10'd1023);
		send_word(32'd41, 10'd10);
		send_word(32'd42, 10'd11);
		send_word(32'd100, 10'd1023);
		send_word(32'd200, 10'd500);
		send_word(32'd1000, 10'd11);
		send_word(32'd1200, 10'd0);

		// Wrapping time: zero elapsed window, saturated power, zero hold time
		configure(0, 0, 3, 0, SCALE_TOP);
		send_word(32'hFFFF_FFFF, 10'd1023);
		send_word(32'h7FFF_FFFF, 10'd1);
		send_word(32'hFFFF_FFFF, 10'd1);
		send_word(32'h7FFF_FFFF, 10'd1);
		send_word(32'hFFFF_FFFF, 10'd1);
		send_word(32'h8000_0000, 10'd1);
		send_word(32'h8000_0000, 10'd0);
		send_word(32'h8000_0001, 10'd0);

		// Report sizes of zero and one count as two
		configure(0, 0, 0, 0, 1000);
		send_word(32'h10, 10'd5);
		send_word(32'h20, 10'd5);
		configure(0, 0, 1, 0, 1000);
		send_word(32'h30, 10'd5);
		send_word(32'h40, 10'd5);

		// Lower the report size in the middle of a window
		configure(0, 0, 10, 0, 1000);
		for (int i = 0; i < 5; i++)
			send_word(32'h100 + i, 10'd5);
		configure(0, 0, 3, 0, 1000);
		send_word(32'h110, 10'd5);

		// Random phases across pacing modes and register extremes
		run_phase(PACE_STEADY, 1'b0, $urandom_range(900), $urandom_range(40),
			$urandom_range(6, 2), $urandom_range(120), $urandom_range(SCALE_TOP, 1), 250);
		run_phase(PACE_SENDER, 1'b1, $urandom_range(900), $urandom_range(40),
			$urandom_range(6, 2), $urandom_range(120), $urandom_range(SCALE_TOP, 1), 250);
		run_phase(PACE_RECEIVER, 1'b0, 0, 0, 2, 0, 1, 200);
		run_phase(PACE_BOTH, 1'b0, 1022, 65535, 255, 65535, SCALE_TOP, 120);
		run_phase(PACE_STEADY, 1'b0, 1023, $urandom_range(40), 2, $urandom_range(120),
			$urandom_range(SCALE_TOP, 1), 40);
		run_phase(PACE_BOTH, 1'b0, $urandom_range(900), $urandom_range(40),
			$urandom_range(8), $urandom_range(120), $urandom_range(SCALE_TOP, 1), 250);
		run_phase(PACE_STEADY, 1'b0, $urandom_range(1023), $urandom_range(65535),
			$urandom_range(255, 2), $urandom_range(65535), $urandom_range(SCALE_TOP, 1), 215);

		settle();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
